### rtl/pairwise_gravity_force_torus_macros.svh
// Assertion macros for the pairwise gravity force block.
// Each macro expects clk and rst_n in the scope that uses it.
`ifndef PAIRWISE_GRAVITY_FORCE_TORUS_MACROS_SVH
`define PAIRWISE_GRAVITY_FORCE_TORUS_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define PGFT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pgft: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define PGFT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pgft: next-cycle check failed");

`endif

### rtl/pgft_pkg.sv
// Package for the pairwise gravity force block: codes, reset values and
// the pipeline stage record. No dependencies.
package pgft_pkg;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_WORLD_WIDTH  = 2'd0;
  localparam logic [1:0] REG_WORLD_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MIN_DIST_SQ  = 2'd2;
  localparam logic [1:0] REG_GRAVITY      = 2'd3;

  // Reset values of the registers
  localparam logic [15:0] RST_WORLD_WIDTH  = 16'd64000;
  localparam logic [15:0] RST_WORLD_HEIGHT = 16'd64000;
  localparam logic [31:0] RST_MIN_DIST_SQ  = 32'd410;
  localparam logic [31:0] RST_GRAVITY      = 32'd18786500;

  // Pair status codes
  localparam logic [1:0] ST_FORCE = 2'd0;
  localparam logic [1:0] ST_CLOSE = 2'd1;
  localparam logic [1:0] ST_MERGE = 2'd2;

  // Saturation limits of a force component (63-bit two's complement)
  localparam logic [62:0] FORCE_POS_MAX = {1'b0, {62{1'b1}}};
  localparam logic [62:0] FORCE_NEG_MIN = {1'b1, 62'd0};

  // Everything one pair carries down the pipeline
  typedef struct packed {
    logic             sx;
    logic             sy;
    logic [15:0]      ax;
    logic [15:0]      ay;
    logic [16:0]      rs;
    logic             heavy;
    logic [39:0]      m1;
    logic [39:0]      m2;
    logic [31:0]      axx;
    logic [31:0]      ayy;
    logic [33:0]      rss;
    logic [47:0]      gx;
    logic [47:0]      gy;
    logic [59:0]      mlo;
    logic [59:0]      mhi;
    logic [32:0]      d2;
    logic             coll;
    logic             close;
    logic [79:0]      mm;
    logic [3:0][67:0] ppx;
    logic [3:0][67:0] ppy;
    logic [1:0][87:0] psx;
    logic [1:0][87:0] psy;
    logic [117:0]     nx;
    logic [117:0]     ny;
    logic [29:0]      sq_rem;
    logic [26:0]      root;
    logic [59:0]      den;
    logic             ovx;
    logic             ovy;
    logic [59:0]      rmx;
    logic [59:0]      rmy;
    logic [62:0]      qx;
    logic [62:0]      qy;
    logic [1:0]       status;
    logic             heavy_o;
    logic [62:0]      fx;
    logic [62:0]      fy;
    logic             sat;
  } pl_t;

endpackage

### rtl/pairwise_gravity_force_torus.sv
// Top level of the pairwise gravity force block on a wrap-around world.
// Depends on pgft_pkg and pairwise_gravity_force_torus_macros.svh.
//
//  channel | direction | word
//  in_     | input     | tdata: pos_x_first, pos_y_first, mass_first, radius_first,
//          |           |        pos_x_second, pos_y_second, mass_second, radius_second
//  out_    | output    | tdata: first_is_heavier, force_x, force_y; tuser: status, sat
//  cfg_    | input     | cfg_index selects the register, cfg_data holds the value
//
// One pair enters per cycle while the output word is not held; its result is offered from the last stage.
// The depth is set by the 27-step square root and the 63-step quotient, one
// step per stage, with the multiplies and the offset math in front.
// rst_n (synchronous) clears the stage valid bits and loads register defaults.
// When the output word is held, every stage holds; nothing is lost or repeated.
module pairwise_gravity_force_torus (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [15:0] pos_x_first, [31:16] pos_y_first, [71:32] mass_first,
  // [87:72] radius_first, [103:88] pos_x_second, [119:104] pos_y_second,
  // [159:120] mass_second, [175:160] radius_second
  input  logic [175:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [0] first_is_heavier, [63:1] force_x, [126:64] force_y, [127] zero
  output logic [127:0] out_tdata,
  // [1:0] pair_status, [2] force_saturated
  output logic [2:0]   out_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import pgft_pkg::*;

  localparam int SQ_FIRST  = 4;
  localparam int SQ_N      = 27;
  localparam int S_DEN     = SQ_FIRST + SQ_N;
  localparam int S_DINIT   = S_DEN + 1;
  localparam int DIV_FIRST = S_DINIT + 1;
  localparam int DIV_N     = 63;
  localparam int S_LAST    = DIV_FIRST + DIV_N - 1;

  logic [15:0] width_r, height_r;
  logic [31:0] min_d2_r, grav_r;

  pl_t         pipe_r   [1:S_LAST];
  pl_t         pipe_nxt [1:S_LAST];
  logic [S_LAST:1] vld_r;
  logic        adv;
  logic [1:0]  out_status;

  // Configuration registers; always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_WORLD_WIDTH;
      height_r <= RST_WORLD_HEIGHT;
      min_d2_r <= RST_MIN_DIST_SQ;
      grav_r   <= RST_GRAVITY;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_WORLD_WIDTH:  width_r  <= cfg_data[15:0];
        REG_WORLD_HEIGHT: height_r <= cfg_data[15:0];
        REG_MIN_DIST_SQ:  min_d2_r <= cfg_data;
        REG_GRAVITY:      grav_r   <= cfg_data;
      endcase
    end
  end

  // Advance the whole pipeline unless the output word is held
  assign adv       = !vld_r[S_LAST] || out_tready;
  assign in_tready = adv;

  // Shortest signed offset on the torus, returned as {sign, magnitude}
  function automatic logic [16:0] wrap_off(input logic [15:0] a, input logic [15:0] b,
                                           input logic [15:0] size);
    logic [17:0] d;
    logic [16:0] m;
    logic [17:0] w;
    logic [17:0] am;
    d = {2'b00, b} - {2'b00, a};
    m = d[17] ? 17'(-d) : d[16:0];
    w = d;
    if ({m[15:0], 1'b0} > {1'b0, size}) begin
      w = d[17] ? d + {2'b00, size} : d - {2'b00, size};
    end
    am = w[17] ? 18'(-w) : w;
    return {w[17], am[15:0]};
  endfunction

  // Sign, clip and pack one force component
  function automatic logic [63:0] fin_force(input logic neg, input logic ovf,
                                            input logic [62:0] q);
    logic        s;
    logic [62:0] v;
    if (neg) begin
      s = ovf || (q[62] && (|q[61:0]));
      v = s ? FORCE_NEG_MIN : 63'(~q + 63'd1);
    end else begin
      s = ovf || q[62];
      v = s ? FORCE_POS_MAX : q;
    end
    return {s, v};
  endfunction

  // Stage 1: wrap offsets, radius sum, mass compare
  always_comb begin
    logic [16:0] ox, oy;
    pipe_nxt[1]       = '0;
    ox                = wrap_off(in_tdata[15:0], in_tdata[103:88], width_r);
    oy                = wrap_off(in_tdata[31:16], in_tdata[119:104], height_r);
    pipe_nxt[1].sx    = ox[16];
    pipe_nxt[1].ax    = ox[15:0];
    pipe_nxt[1].sy    = oy[16];
    pipe_nxt[1].ay    = oy[15:0];
    pipe_nxt[1].rs    = {1'b0, in_tdata[87:72]} + {1'b0, in_tdata[175:160]};
    pipe_nxt[1].m1    = in_tdata[71:32];
    pipe_nxt[1].m2    = in_tdata[159:120];
    pipe_nxt[1].heavy = in_tdata[71:32] >= in_tdata[159:120];
  end

  genvar k;
  generate
    for (k = 2; k <= S_LAST; k++) begin : g_stg
      if (k == 2) begin : g_sq
        // Squares, G times offsets, mass product halves
        always_comb begin
          pipe_nxt[k]     = pipe_r[k-1];
          pipe_nxt[k].axx = pipe_r[k-1].ax * pipe_r[k-1].ax;
          pipe_nxt[k].ayy = pipe_r[k-1].ay * pipe_r[k-1].ay;
          pipe_nxt[k].rss = pipe_r[k-1].rs * pipe_r[k-1].rs;
          pipe_nxt[k].gx  = grav_r * pipe_r[k-1].ax;
          pipe_nxt[k].gy  = grav_r * pipe_r[k-1].ay;
          pipe_nxt[k].mlo = pipe_r[k-1].m1 * pipe_r[k-1].m2[19:0];
          pipe_nxt[k].mhi = pipe_r[k-1].m1 * pipe_r[k-1].m2[39:20];
        end
      end else if (k == 3) begin : g_sum
        // Distance squared, merge and near tests, full mass product
        always_comb begin
          logic [32:0] d2;
          d2                 = {1'b0, pipe_r[k-1].axx} + {1'b0, pipe_r[k-1].ayy};
          pipe_nxt[k]        = pipe_r[k-1];
          pipe_nxt[k].d2     = d2;
          pipe_nxt[k].coll   = {d2, 4'b0000} <= {3'b000, pipe_r[k-1].rss};
          pipe_nxt[k].close  = d2 < {1'b0, min_d2_r};
          pipe_nxt[k].mm     = {20'd0, pipe_r[k-1].mlo} + {pipe_r[k-1].mhi, 20'd0};
          pipe_nxt[k].sq_rem = '0;
          pipe_nxt[k].root   = '0;
        end
      end else if (k < S_DEN) begin : g_root
        // One root digit per stage; numerator products ride alongside
        localparam int PI = SQ_N - 1 - (k - SQ_FIRST);
        always_comb begin
          logic [53:0] sv;
          logic [29:0] t;
          logic [29:0] trial;
          sv          = {1'b0, pipe_r[k-1].d2, 20'd0};
          t           = {pipe_r[k-1].sq_rem[27:0], sv[2*PI +: 2]};
          trial       = {1'b0, pipe_r[k-1].root, 2'b01};
          pipe_nxt[k] = pipe_r[k-1];
          if (t >= trial) begin
            pipe_nxt[k].sq_rem = t - trial;
            pipe_nxt[k].root   = {pipe_r[k-1].root[25:0], 1'b1};
          end else begin
            pipe_nxt[k].sq_rem = t;
            pipe_nxt[k].root   = {pipe_r[k-1].root[25:0], 1'b0};
          end
          if (k == SQ_FIRST) begin
            for (int j = 0; j < 4; j++) begin
              pipe_nxt[k].ppx[j] = pipe_r[k-1].mm[20*j +: 20] * pipe_r[k-1].gx;
              pipe_nxt[k].ppy[j] = pipe_r[k-1].mm[20*j +: 20] * pipe_r[k-1].gy;
            end
          end
          if (k == SQ_FIRST + 1) begin
            for (int j = 0; j < 2; j++) begin
              pipe_nxt[k].psx[j] = {20'd0, pipe_r[k-1].ppx[2*j]}
                                 + {pipe_r[k-1].ppx[2*j+1], 20'd0};
              pipe_nxt[k].psy[j] = {20'd0, pipe_r[k-1].ppy[2*j]}
                                 + {pipe_r[k-1].ppy[2*j+1], 20'd0};
            end
          end
          if (k == SQ_FIRST + 2) begin
            logic [127:0] fullx, fully;
            fullx = {40'd0, pipe_r[k-1].psx[0]} + {pipe_r[k-1].psx[1], 40'd0};
            fully = {40'd0, pipe_r[k-1].psy[0]} + {pipe_r[k-1].psy[1], 40'd0};
            pipe_nxt[k].nx = fullx[127:10];
            pipe_nxt[k].ny = fully[127:10];
          end
        end
      end else if (k == S_DEN) begin : g_den
        // Divisor: distance squared times distance
        always_comb begin
          pipe_nxt[k]     = pipe_r[k-1];
          pipe_nxt[k].den = pipe_r[k-1].d2 * pipe_r[k-1].root;
        end
      end else if (k == S_DINIT) begin : g_dinit
        // Flag quotients of 2^63 and up, seed the remainders
        always_comb begin
          logic [59:0] hx, hy;
          hx               = {5'd0, pipe_r[k-1].nx[117:63]};
          hy               = {5'd0, pipe_r[k-1].ny[117:63]};
          pipe_nxt[k]      = pipe_r[k-1];
          pipe_nxt[k].ovx  = hx >= pipe_r[k-1].den;
          pipe_nxt[k].ovy  = hy >= pipe_r[k-1].den;
          pipe_nxt[k].rmx  = (hx >= pipe_r[k-1].den) ? '0 : hx;
          pipe_nxt[k].rmy  = (hy >= pipe_r[k-1].den) ? '0 : hy;
          pipe_nxt[k].qx   = '0;
          pipe_nxt[k].qy   = '0;
        end
      end else if (k < S_LAST) begin : g_div
        // One quotient bit per stage for each component
        localparam int QB = DIV_N - 1 - (k - DIV_FIRST);
        always_comb begin
          logic [60:0] tx, ty;
          tx          = {pipe_r[k-1].rmx, pipe_r[k-1].nx[QB]};
          ty          = {pipe_r[k-1].rmy, pipe_r[k-1].ny[QB]};
          pipe_nxt[k] = pipe_r[k-1];
          if (tx >= {1'b0, pipe_r[k-1].den}) begin
            pipe_nxt[k].rmx    = 60'(tx - {1'b0, pipe_r[k-1].den});
            pipe_nxt[k].qx[QB] = 1'b1;
          end else begin
            pipe_nxt[k].rmx    = tx[59:0];
          end
          if (ty >= {1'b0, pipe_r[k-1].den}) begin
            pipe_nxt[k].rmy    = 60'(ty - {1'b0, pipe_r[k-1].den});
            pipe_nxt[k].qy[QB] = 1'b1;
          end else begin
            pipe_nxt[k].rmy    = ty[59:0];
          end
        end
      end else begin : g_fin
        // Last quotient bit, then sign, clip and pick the status
        always_comb begin
          logic [60:0] tx, ty;
          logic [62:0] qx, qy;
          logic [63:0] rx, ry;
          tx = {pipe_r[k-1].rmx, pipe_r[k-1].nx[0]};
          ty = {pipe_r[k-1].rmy, pipe_r[k-1].ny[0]};
          qx = {pipe_r[k-1].qx[62:1], tx >= {1'b0, pipe_r[k-1].den}};
          qy = {pipe_r[k-1].qy[62:1], ty >= {1'b0, pipe_r[k-1].den}};
          rx = fin_force(pipe_r[k-1].sx, pipe_r[k-1].ovx, qx);
          ry = fin_force(pipe_r[k-1].sy, pipe_r[k-1].ovy, qy);
          pipe_nxt[k]         = pipe_r[k-1];
          pipe_nxt[k].status  = ST_FORCE;
          pipe_nxt[k].heavy_o = 1'b0;
          pipe_nxt[k].fx      = '0;
          pipe_nxt[k].fy      = '0;
          pipe_nxt[k].sat     = 1'b0;
          if (pipe_r[k-1].coll) begin
            pipe_nxt[k].status  = ST_MERGE;
            pipe_nxt[k].heavy_o = pipe_r[k-1].heavy;
          end else if (pipe_r[k-1].close) begin
            pipe_nxt[k].status  = ST_CLOSE;
          end else begin
            pipe_nxt[k].fx  = rx[62:0];
            pipe_nxt[k].fy  = ry[62:0];
            pipe_nxt[k].sat = rx[63] || ry[63];
          end
        end
      end
    end
  endgenerate

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[S_LAST-1:1], in_tvalid};
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int s = 1; s <= S_LAST; s++) begin
        pipe_r[s] <= pipe_nxt[s];
      end
    end
  end

  // Drive the result word from the last stage
  assign out_tvalid = vld_r[S_LAST];
  assign out_tdata  = {1'b0, pipe_r[S_LAST].fy, pipe_r[S_LAST].fx, pipe_r[S_LAST].heavy_o};
  assign out_tuser  = {pipe_r[S_LAST].sat, pipe_r[S_LAST].status};
  assign out_status = out_tuser[1:0];

`include "pairwise_gravity_force_torus_macros.svh"

  `PGFT_ASSERT_IMP(a_merge_no_force, out_tvalid && out_status == ST_MERGE, out_tdata[126:1] == '0)
  `PGFT_ASSERT_IMP(a_heavy_only_merge, out_tvalid && out_status != ST_MERGE, !out_tdata[0])
  `PGFT_ASSERT_IMP(a_status_legal, out_tvalid, out_status <= ST_MERGE)
  `PGFT_ASSERT_NXT(a_accept_enters, in_tvalid && in_tready, vld_r[1])

endmodule
